// File: sv/scps_pkg.sv
// Package for the caseless pattern scan: payload types, register codes and byte constants.
`default_nettype none

package scps_pkg;

	localparam int PATTERN_MAX_DEF = 8;

	localparam logic [7:0] BYTE_EOF_MARK = 8'h1A;
	localparam logic [7:0] BYTE_CR       = 8'h0D;
	localparam logic [7:0] CASE_DELTA    = 8'd32;
	localparam logic [7:0] CHAR_UPPER_A  = 8'h41;
	localparam logic [7:0] CHAR_UPPER_Z  = 8'h5A;

	localparam int CFG_ADDR_W = 5;
	localparam int CFG_DATA_W = 64;

	typedef enum logic [1:0] {
		REG_PATTERN_BYTES  = 2'd0,
		REG_PATTERN_LENGTH = 2'd1,
		REG_SCAN_DIRECTION = 2'd2,
		REG_START_OFFSET   = 2'd3
	} reg_index_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       range_end;
	} src_item_t;

	typedef struct packed {
		logic        found;
		logic [30:0] match_offset;
	} res_item_t;

	typedef struct packed {
		logic [63:0] pattern_bytes;
		logic [3:0]  pattern_length;
		logic        scan_direction;
		logic [30:0] start_offset;
	} scan_cfg_t;

	// Fold A-Z to lower case.
	function automatic logic [7:0] fold_case(input logic [7:0] c);
		fold_case = (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) ? c + CASE_DELTA : c;
	endfunction

endpackage

`default_nettype wire

// File: sv/scps_cfg_regs.sv
// Configuration register file behind the APB-style port.
`default_nettype none

module scps_cfg_regs (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             psel,
	input  wire logic                             penable,
	input  wire logic                             pwrite,
	input  wire logic [scps_pkg::CFG_ADDR_W-1:0]  paddr,
	input  wire logic [scps_pkg::CFG_DATA_W-1:0]  pwdata,
	output logic      [scps_pkg::CFG_DATA_W-1:0]  prdata,
	output logic                                  pready,
	output scps_pkg::scan_cfg_t                   cfg
);
	import scps_pkg::*;

	scan_cfg_t  cfg_q;
	reg_index_t sel_idx;
	logic       wr_en;

	assign pready  = 1'b1;
	assign sel_idx = reg_index_t'(paddr[4:3]);
	assign wr_en   = psel && penable && pwrite && pready;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (sel_idx)
				REG_PATTERN_BYTES:  cfg_q.pattern_bytes  <= pwdata;
				REG_PATTERN_LENGTH: cfg_q.pattern_length <= pwdata[3:0];
				REG_SCAN_DIRECTION: cfg_q.scan_direction <= pwdata[0];
				REG_START_OFFSET:   cfg_q.start_offset   <= pwdata[30:0];
				default:            cfg_q <= cfg_q;
			endcase
		end
	end

	always_comb begin
		unique case (sel_idx)
			REG_PATTERN_BYTES:  prdata = cfg_q.pattern_bytes;
			REG_PATTERN_LENGTH: prdata = {60'd0, cfg_q.pattern_length};
			REG_SCAN_DIRECTION: prdata = {63'd0, cfg_q.scan_direction};
			REG_START_OFFSET:   prdata = {33'd0, cfg_q.start_offset};
			default:            prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

// File: sv/scps_match_core.sv
// Input register, one-pass match update and result register of the pattern scan.
`default_nettype none

module scps_match_core #(
	parameter int PATTERN_MAX = scps_pkg::PATTERN_MAX_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire scps_pkg::scan_cfg_t  cfg,
	input  wire logic                 src_valid,
	output logic                      src_stall,
	input  wire scps_pkg::src_item_t  src_item,
	output logic                      res_valid,
	input  wire logic                 res_stall,
	output scps_pkg::res_item_t       res_item
);
	import scps_pkg::*;

	localparam int IDX_W = $clog2(PATTERN_MAX + 1);
	localparam logic [3:0] PMAX4 = 4'(PATTERN_MAX);

	// input stage
	logic      valid_s1;
	src_item_t item_s1;

	// scan state
	logic [IDX_W-1:0] match_index_q;
	logic [30:0]      candidate_start_q;
	logic [30:0]      last_match_q;
	logic             last_match_valid_q;
	logic [30:0]      byte_position_q;
	logic             scan_stopped_q;

	// result register
	logic      res_valid_q;
	res_item_t res_item_q;

	logic             fire;
	logic [7:0]       c;
	logic [3:0]       plen4;
	logic [IDX_W-1:0] plen;
	logic [7:0]       pat_cur;
	logic [7:0]       pat_first;
	logic [31:0]      idx32;
	logic [IDX_W-1:0] mi_inc;

	logic [IDX_W-1:0] mi_n;
	logic [30:0]      cs_n;
	logic [30:0]      lm_n;
	logic             lmv_n;
	logic             stop_n;
	logic             emit;
	logic             emit_found;
	logic [30:0]      emit_rel;

	assign fire      = valid_s1 && !(res_valid_q && res_stall);
	assign src_stall = valid_s1 && res_valid_q && res_stall;
	assign res_valid = res_valid_q;
	assign res_item  = res_item_q;

	assign c         = fold_case(item_s1.data_byte);
	assign plen4     = (cfg.pattern_length > PMAX4) ? PMAX4 : cfg.pattern_length;
	assign plen      = plen4[IDX_W-1:0];
	assign idx32     = 32'(match_index_q);
	assign pat_cur   = cfg.pattern_bytes[{idx32[2:0], 3'b000} +: 8];
	assign pat_first = cfg.pattern_bytes[7:0];
	assign mi_inc    = match_index_q + 1'b1;

	always_comb begin
		mi_n       = match_index_q;
		cs_n       = candidate_start_q;
		lm_n       = last_match_q;
		lmv_n      = last_match_valid_q;
		stop_n     = scan_stopped_q;
		emit       = 1'b0;
		emit_found = 1'b0;
		emit_rel   = '0;

		if (!scan_stopped_q) begin
			if (item_s1.data_byte == BYTE_EOF_MARK) begin
				stop_n = 1'b1;
			end else if (item_s1.data_byte != BYTE_CR) begin
				if (plen != '0 && c == pat_cur) begin
					if (match_index_q == '0) begin
						cs_n = byte_position_q;
					end
					if (mi_inc >= plen) begin
						lm_n  = cs_n;
						lmv_n = 1'b1;
						mi_n  = '0;
						if (!cfg.scan_direction) begin
							stop_n     = 1'b1;
							emit       = 1'b1;
							emit_found = 1'b1;
							emit_rel   = cs_n;
						end
					end else begin
						mi_n = mi_inc;
					end
				end else if (match_index_q != '0) begin
					mi_n = '0;
					// retry the current byte as a fresh start
					if (plen != '0 && c == pat_first) begin
						cs_n = byte_position_q;
						mi_n = IDX_W'(1);
					end
				end
			end
		end

		if (item_s1.range_end && !emit) begin
			if (cfg.scan_direction) begin
				emit       = 1'b1;
				emit_found = lmv_n;
				emit_rel   = lm_n;
			end else if (!lmv_n) begin
				emit = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!src_stall) begin
			valid_s1 <= src_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!src_stall && src_valid) begin
			item_s1 <= src_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_index_q      <= '0;
			candidate_start_q  <= '0;
			last_match_q       <= '0;
			last_match_valid_q <= 1'b0;
			byte_position_q    <= '0;
			scan_stopped_q     <= 1'b0;
		end else if (fire) begin
			if (item_s1.range_end) begin
				match_index_q      <= '0;
				candidate_start_q  <= '0;
				last_match_q       <= '0;
				last_match_valid_q <= 1'b0;
				byte_position_q    <= '0;
				scan_stopped_q     <= 1'b0;
			end else begin
				match_index_q      <= mi_n;
				candidate_start_q  <= cs_n;
				last_match_q       <= lm_n;
				last_match_valid_q <= lmv_n;
				scan_stopped_q     <= stop_n;
				if (!scan_stopped_q) begin
					byte_position_q <= byte_position_q + 31'd1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (fire && emit) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && emit) begin
			res_item_q.found        <= emit_found;
			res_item_q.match_offset <= emit_found ? cfg.start_offset + emit_rel : 31'd0;
		end
	end

	a_stopped_holds_position: assert property (@(posedge clk) disable iff (!arst_n)
		fire && scan_stopped_q && !item_s1.range_end |=> $stable(byte_position_q))
		else $error("byte position moved while the scan was stopped");

	a_range_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item_s1.range_end |=> byte_position_q == '0 && !scan_stopped_q
			&& !last_match_valid_q && match_index_q == '0)
		else $error("scan state not cleared after range end");

	a_result_from_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(fire))
		else $error("result appeared without an input transfer");

	a_forward_hit_stops: assert property (@(posedge clk) disable iff (!arst_n)
		fire && emit && emit_found && !cfg.scan_direction && !item_s1.range_end
			|=> scan_stopped_q)
		else $error("forward match did not stop the scan");

endmodule

`default_nettype wire

// File: sv/stream_caseless_pattern_scan.sv
// Top level of the streaming caseless pattern scan.
//
// Source channel (src_valid/src_stall/src_item) carries one file byte per
// transfer plus a range_end flag on the last byte of the range. Result
// channel (res_valid/res_stall/res_item) carries found and match_offset:
// in forward mode one result at the first match, in backward mode one
// result at range end; a range with no match gives found=0 at its end.
// Pattern, length, direction and start offset are written over the APB
// port; the user must write them only while the stream is idle, as the
// block has no check for it. Throughput: one byte per cycle unless
// res_stall holds a waiting result. A byte is taken into the input
// register; the match update works on it there and writes the result
// register, which drives res_valid. The limit is the combinational
// compare and state update of the match stage. While res_stall holds a
// waiting result, one more byte is taken into the input register;
// src_stall rises only once that register is full too. Reset clears the
// configuration, scan state and valid flags; no result is pending afterwards.
`default_nettype none

module stream_caseless_pattern_scan #(
	parameter int PATTERN_MAX = scps_pkg::PATTERN_MAX_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             src_valid,
	output logic                                  src_stall,
	input  wire scps_pkg::src_item_t              src_item,
	output logic                                  res_valid,
	input  wire logic                             res_stall,
	output scps_pkg::res_item_t                   res_item,
	input  wire logic                             psel,
	input  wire logic                             penable,
	input  wire logic                             pwrite,
	input  wire logic [scps_pkg::CFG_ADDR_W-1:0]  paddr,
	input  wire logic [scps_pkg::CFG_DATA_W-1:0]  pwdata,
	output logic      [scps_pkg::CFG_DATA_W-1:0]  prdata,
	output logic                                  pready
);
	import scps_pkg::*;

	scan_cfg_t cfg;

	scps_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	scps_match_core #(
		.PATTERN_MAX (PATTERN_MAX)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.src_item  (src_item),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_item  (res_item)
	);

endmodule

`default_nettype wire

// File: tb/tb_stream_caseless_pattern_scan.sv
// Self-checking testbench for the streaming caseless pattern scan: scoreboard, stimulus, APB setup.
`timescale 1ns / 1ps

module tb_stream_caseless_pattern_scan;
	import scps_pkg::*;

	class match_scoreboard;
		logic [63:0] pat_bytes;
		logic [3:0]  pat_len;
		logic        backward;
		logic [30:0] base_offset;

		logic [3:0]  matched_len;
		logic [30:0] cand_pos;
		logic [30:0] last_hit_pos;
		logic        hit_held;
		logic [30:0] cur_pos;
		logic        halted;

		res_item_t   expected_reports[$];
		int          errors;
		int          checked;
		int          found_cnt;
		int          missing_cnt;

		function new();
			pat_bytes   = '0;
			pat_len     = '0;
			backward    = 1'b0;
			base_offset = '0;
			errors      = 0;
			checked     = 0;
			found_cnt   = 0;
			missing_cnt = 0;
			clear_scan();
		endfunction

		function void clear_scan();
			matched_len  = '0;
			cand_pos     = '0;
			last_hit_pos = '0;
			hit_held     = 1'b0;
			cur_pos      = '0;
			halted       = 1'b0;
		endfunction

		function void set_reg(reg_index_t idx, logic [63:0] value);
			case (idx)
				REG_PATTERN_BYTES:  pat_bytes = value;
				REG_PATTERN_LENGTH: pat_len = value[3:0];
				REG_SCAN_DIRECTION: backward = value[0];
				REG_START_OFFSET:   base_offset = value[30:0];
				default: ;
			endcase
		endfunction

		function void queue_report(logic hit, logic [30:0] rel);
			res_item_t r;
			r.found = hit;
			r.match_offset = hit ? base_offset + rel : 31'd0;
			expected_reports.push_back(r);
		endfunction

		// Advance the scan by one accepted byte and queue whatever it reports.
		function void note_byte(src_item_t it);
			logic [7:0] c;
			logic [3:0] lim;
			logic [2:0] sel;
			bit         reported;
			c = it.data_byte;
			lim = (pat_len > PATTERN_MAX_DEF) ? 4'(PATTERN_MAX_DEF) : pat_len;
			reported = 1'b0;
			if (!halted) begin
				if (c == BYTE_EOF_MARK) begin
					halted = 1'b1;
				end else if (c != BYTE_CR) begin
					if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z)
						c = c + CASE_DELTA;
					sel = matched_len[2:0];
					if (lim != 0 && c == pat_bytes[8*sel +: 8]) begin
						if (matched_len == 0)
							cand_pos = cur_pos;
						matched_len = matched_len + 4'd1;
						if (matched_len >= lim) begin
							last_hit_pos = cand_pos;
							hit_held = 1'b1;
							matched_len = '0;
							if (!backward) begin
								halted = 1'b1;
								queue_report(1'b1, last_hit_pos);
								reported = 1'b1;
							end
						end
					end else if (matched_len != 0) begin
						// simple restart: only the current byte is retried
						matched_len = '0;
						if (lim != 0 && c == pat_bytes[7:0]) begin
							cand_pos = cur_pos;
							matched_len = 4'd1;
						end
					end
				end
				cur_pos = cur_pos + 31'd1;
			end
			if (it.range_end) begin
				if (!reported) begin
					if (backward)
						queue_report(hit_held, last_hit_pos);
					else if (!hit_held)
						queue_report(1'b0, 31'd0);
				end
				clear_scan();
			end
		endfunction

		task report(string msg);
			$display("MISMATCH @%0t: %s", $time, msg);
			errors++;
		endtask

		task check_result(res_item_t got);
			res_item_t want;
			if (expected_reports.size() == 0) begin
				report($sformatf("result with nothing pending: found=%0b offset=%h",
					got.found, got.match_offset));
				return;
			end
			want = expected_reports.pop_front();
			checked++;
			if (want.found)
				found_cnt++;
			else
				missing_cnt++;
			if (got.found !== want.found)
				report($sformatf("found got %0b want %0b", got.found, want.found));
			if (got.match_offset !== want.match_offset)
				report($sformatf("match_offset got %h want %h",
					got.match_offset, want.match_offset));
		endtask

		task drain_check();
			if (expected_reports.size() != 0)
				report($sformatf("%0d results never arrived", expected_reports.size()));
		endtask

		function int pending();
			return expected_reports.size();
		endfunction
	endclass

	localparam int SETTLE_CYCLES  = 8;
	localparam int TAIL_CYCLES    = 10;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int LONG_HOLD      = 300;
	localparam int RANDOM_ITEMS   = 1700;

	logic                  clk;
	logic                  arst_n;
	logic                  src_valid;
	logic                  src_stall;
	src_item_t             src_item;
	logic                  res_valid;
	logic                  res_stall;
	res_item_t             res_item;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [CFG_DATA_W-1:0] pwdata;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;

	match_scoreboard sb;
	int  bytes_sent;
	int  settings_used;
	int  quiet_cycles;
	bit  steady;
	bit  long_hold_done;

	stream_caseless_pattern_scan u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.src_item  (src_item),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_item  (res_item),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// transfer monitors
	always @(posedge clk) begin
		if (arst_n && src_valid && !src_stall)
			sb.note_byte(src_item);
		if (arst_n && res_valid && !res_stall)
			sb.check_result(res_item);
	end

	always @(posedge clk) begin
		if (arst_n && ((src_valid && !src_stall) || (res_valid && !res_stall))) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout: no transfer for %0d cycles", quiet_cycles);
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// result side: random hold-offs, runs without any, and one long hold
	initial begin
		int hold;
		int steady_left;
		steady_left = 0;
		res_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (!long_hold_done && bytes_sent >= 800) begin
				hold = LONG_HOLD;
				long_hold_done = 1'b1;
			end else if (steady_left > 0) begin
				hold = 0;
				steady_left--;
			end else begin
				hold = $urandom_range(0, 4);
				if ($urandom_range(0, 7) == 0)
					steady_left = 25;
			end
			if (hold != 0) begin
				res_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			res_stall <= 1'b0;
			do @(posedge clk); while (!res_valid);
		end
	end

	task automatic send_item(input logic [7:0] b, input logic close);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 4);
		if (gap != 0) begin
			src_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		src_valid <= 1'b1;
		src_item <= {b, close};
		do @(posedge clk); while (src_stall);
		bytes_sent++;
	endtask

	task automatic send_text(input string s, input bit close);
		for (int i = 0; i < s.len(); i++)
			send_item(s[i], close && (i == s.len() - 1));
	endtask

	task automatic reg_write(input reg_index_t idx, input logic [63:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 3'b000};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_reg(idx, value);
	endtask

	// Registers only change once the stream has drained.
	task automatic configure(input logic [63:0] pat, input logic [3:0] len,
			input logic dir, input logic [30:0] base);
		src_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		reg_write(REG_PATTERN_BYTES, pat);
		reg_write(REG_PATTERN_LENGTH, {60'd0, len});
		reg_write(REG_SCAN_DIRECTION, {63'd0, dir});
		reg_write(REG_START_OFFSET, {33'd0, base});
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		settings_used++;
	endtask

	function automatic logic [63:0] letter_pattern();
		logic [63:0] p;
		for (int k = 0; k < 8; k++)
			p[8*k +: 8] = 8'h61 + 8'($urandom_range(0, 3));
		return p;
	endfunction

	// One range built mostly from pattern pieces: full copies, broken prefixes,
	// mixed case, CRs, an occasional end-of-file mark, and plain noise.
	task automatic send_range(input logic [63:0] pat, input int plen);
		logic [7:0] text[$];
		logic [7:0] c;
		int         target;
		int         cut;
		int         r;
		target = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 16);
		while (text.size() < target) begin
			r = $urandom_range(0, 99);
			if (r < 30 && plen > 0) begin
				cut = (r < 20) ? plen : $urandom_range(1, plen);
				for (int k = 0; k < cut; k++) begin
					c = pat[8*k +: 8];
					if (c >= "a" && c <= "z" && $urandom_range(0, 1) == 1)
						c = c - CASE_DELTA;
					text.push_back(c);
					if ($urandom_range(0, 15) == 0)
						text.push_back(BYTE_CR);
				end
			end else if (r < 70 && plen > 0) begin
				text.push_back(pat[8*$urandom_range(0, plen - 1) +: 8]);
			end else if (r < 78) begin
				text.push_back(BYTE_CR);
			end else if (r < 80) begin
				text.push_back(BYTE_EOF_MARK);
			end else begin
				text.push_back(8'($urandom_range(0, 255)));
			end
		end
		foreach (text[i])
			send_item(text[i], i == text.size() - 1);
	endtask

	task automatic random_phase(input int p);
		logic [63:0] pat;
		logic [3:0]  len;
		logic        dir;
		logic [30:0] base;
		int          r;
		int          stop_at;
		case (p)
			0: begin
				pat = '1; len = 4'd15; dir = 1'b1; base = 31'h7FFF_FFFF;
			end
			1: begin
				pat = letter_pattern(); len = 4'd8; dir = 1'b0; base = '0;
			end
			2: begin
				pat = '0; len = 4'd1; dir = 1'b0; base = 31'h7FFF_FFF0;
			end
			default: begin
				pat = ($urandom_range(0, 5) == 0) ? {$urandom, $urandom} : letter_pattern();
				r = $urandom_range(0, 9);
				if (r == 0)
					len = 4'd0;
				else if (r == 1)
					len = 4'($urandom_range(9, 15));
				else if (r < 6)
					len = 4'($urandom_range(1, 3));
				else
					len = 4'($urandom_range(4, 8));
				dir = 1'($urandom_range(0, 1));
				r = $urandom_range(0, 4);
				if (r == 0)
					base = '0;
				else if (r == 1)
					base = 31'h7FFF_FFFF - 31'($urandom_range(0, 64));
				else
					base = 31'($urandom);
			end
		endcase
		configure(pat, len, dir, base);
		steady = ($urandom_range(0, 3) == 0);
		stop_at = bytes_sent + 120;
		while (bytes_sent < stop_at)
			send_range(pat, (len > PATTERN_MAX_DEF) ? PATTERN_MAX_DEF : int'(len));
	endtask

	initial begin
		int goal;
		sb = new();
		bytes_sent = 0;
		settings_used = 0;
		long_hold_done = 1'b0;
		steady = 1'b0;
		quiet_cycles <= 0;
		arst_n    <= 1'b0;
		src_valid <= 1'b0;
		src_item  <= '0;
		psel      <= 1'b0;
		penable   <= 1'b0;
		pwrite    <= 1'b0;
		paddr     <= '0;
		pwdata    <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: empty pattern, so the range ends not found
		send_item(8'h00, 1'b0);
		send_item(8'hFF, 1'b1);

		// forward, offset sums to the top value, restart on a repeated first byte,
		// CR skipped inside the match, bytes after the hit ignored
		configure(64'h0000_0000_0063_6261, 4'd3, 1'b0, 31'h7FFF_FFFE);
		send_text("AaB", 1'b0);
		send_item(BYTE_CR, 1'b0);
		send_text("Cz", 1'b1);

		// backward: last match before the end-of-file mark wins
		configure(64'h0000_0000_0063_6261, 4'd3, 1'b1, 31'd0);
		send_text("abcxABC", 1'b0);
		send_item(BYTE_EOF_MARK, 1'b0);
		send_text("abc", 1'b1);
		send_text("q", 1'b1);

		// forward with the end-of-file mark ahead of the pattern
		configure(64'h0000_0000_0063_6261, 4'd3, 1'b0, 31'd0);
		send_item(BYTE_EOF_MARK, 1'b0);
		send_text("abc", 1'b1);

		goal = bytes_sent + RANDOM_ITEMS;
		for (int p = 0; bytes_sent < goal; p++)
			random_phase(p);

		src_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		sb.drain_check();

		$display("Scanned %0d bytes under %0d register settings; %0d results checked",
			bytes_sent, settings_used, sb.checked);
		$display("  (%0d found, %0d not found), long result hold-off %s, %0d mismatches",
			sb.found_cnt, sb.missing_cnt, long_hold_done ? "done" : "skipped", sb.errors);
		if (sb.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
